// ===== hdl/median_bias_adjustment_terms_core_assert.svh =====
// Assertion macros shared by the median bias adjustment core.
`ifndef MEDIAN_BIAS_ADJUSTMENT_TERMS_CORE_ASSERT_SVH
`define MEDIAN_BIAS_ADJUSTMENT_TERMS_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define MBAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MBAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mbat_pkg.sv =====
// Types, codes and fixed-point helpers for the median bias adjustment core.
package mbat_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int MAX_ROWS    = 8;
    localparam int DIM_W       = 4;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD_INFO  = 2'd0,
        OP_LOAD_THIRD = 2'd1,
        OP_LOAD_MIXED = 2'd2,
        OP_COMPUTE    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [8:0]         flat_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         row_index;
        logic signed [31:0] adjustment;
        logic               divide_error;
        logic               last;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        return sat32(p >>> 16);
    endfunction

endpackage

// ===== hdl/mbat_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mbat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/median_bias_adjustment_terms_core.sv =====
// Top level: stores, sequencer, shared multiplier and divider of the adjustment core.
//
// Load items (matrix or tensor elements) are written to the stores as they are accepted and busy stays low.
// A compute item raises busy and emits one result per row r = 0..n-1 on
// result_strobe, one cycle each; the receiver must take every result as it comes.
// A row whose diagonal is zero skips the divider and gets divide_error. Any other
// row sums n*n*(n+1)/2 (s,t,u) terms; each term makes one pass through the
// shared radix-2 divider (one quotient bit per cycle over 64 bits), and
// the reciprocal of the diagonal and the final scaling use the same divider.
// Store contents are undefined until loaded.
`include "median_bias_adjustment_terms_core_assert.svh"

module median_bias_adjustment_terms_core
    import mbat_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_wdata,
    output logic             result_strobe,
    output result_t          result
);

    localparam int ND  = (MAX_DIM < MAX_ROWS) ? MAX_DIM : MAX_ROWS;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;
    localparam int NW  = $clog2(ND + 1);
    localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
    localparam int TEN_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int MAW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int TAW = (TEN_DEPTH > 1) ? $clog2(TEN_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DIAG_RD, S_DIAG_CHK, S_K2_DIV, S_K2_SQ, S_K2_CUBE,
        S_IRS, S_IRT, S_ITR, S_IRU, S_ITU, S_PROD, S_NU_START, S_NU_DIV,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_ACC,
        S_FIN_START, S_FIN_DIV
    } state_t;

    state_t             state_reg;
    logic [DIM_W-1:0]   dim_reg;
    logic [NW-1:0]      n_reg;
    logic [CW-1:0]      r_reg, s_reg, t_reg, u_reg;
    logic signed [31:0] d_reg, k2_reg, k2c_reg, p_reg, nu_reg, ab_reg;
    logic signed [31:0] irs_reg, irt_reg, itr_reg, iru_reg, itu_reg, a_reg;
    logic signed [63:0] first_reg, third_reg;
    logic               strobe_reg;
    result_t            result_reg;

    logic               div_run_reg, div_neg_reg;
    logic [5:0]         div_cnt_reg;
    logic [63:0]        div_quo_reg, div_rem_reg, div_dv_reg;

    logic               accept;
    logic [NW-1:0]      n_eff;
    logic [CW-1:0]      n_last;
    logic               row_last;
    logic [31:0]        idx_ext;
    logic [MAW-1:0]     info_raddr;
    logic [TAW-1:0]     tens_raddr;
    logic [31:0]        info_rdata, third_rdata, mixed_rdata;
    logic signed [31:0] info_q, third_q, mixed_q;
    logic               we_info, we_third, we_mixed;
    logic signed [31:0] mul_a, mul_b, mul_y;
    logic               div_start;
    logic signed [63:0] div_num, div_den;
    logic [63:0]        div_num_mag, div_den_mag;
    logic [64:0]        div_shift, div_diff;
    logic signed [63:0] div_q;
    logic signed [63:0] den_fin;
    logic signed [63:0] p_wide, p_weighted;
    logic signed [63:0] fin_sum;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign idx_ext  = 32'(item.flat_index);
    assign we_info  = accept && (item.op == OP_LOAD_INFO)  && (idx_ext < 32'(MAT_DEPTH));
    assign we_third = accept && (item.op == OP_LOAD_THIRD) && (idx_ext < 32'(TEN_DEPTH));
    assign we_mixed = accept && (item.op == OP_LOAD_MIXED) && (idx_ext < 32'(TEN_DEPTH));

    always_comb
    begin
        if (dim_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(dim_reg) > ND)
        begin
            n_eff = NW'(ND);
        end
        else
        begin
            n_eff = NW'(dim_reg);
        end
    end

    assign n_last   = CW'(n_reg - NW'(1));
    assign row_last = ((NW'(r_reg) + NW'(1)) == n_reg);

    mbat_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_info_ram (
        .clk   (clk),
        .we    (we_info),
        .waddr (idx_ext[MAW-1:0]),
        .wdata (item.value),
        .raddr (info_raddr),
        .rdata (info_rdata)
    );

    mbat_ram #(.WIDTH(32), .DEPTH(TEN_DEPTH)) u_third_ram (
        .clk   (clk),
        .we    (we_third),
        .waddr (idx_ext[TAW-1:0]),
        .wdata (item.value),
        .raddr (tens_raddr),
        .rdata (third_rdata)
    );

    mbat_ram #(.WIDTH(32), .DEPTH(TEN_DEPTH)) u_mixed_ram (
        .clk   (clk),
        .we    (we_mixed),
        .waddr (idx_ext[TAW-1:0]),
        .wdata (item.value),
        .raddr (tens_raddr),
        .rdata (mixed_rdata)
    );

    assign info_q  = info_rdata;
    assign third_q = third_rdata;
    assign mixed_q = mixed_rdata;

    assign tens_raddr = TAW'(s_reg) + TAW'(t_reg) * TAW'(n_reg)
                      + TAW'(u_reg) * TAW'(n_reg) * TAW'(n_reg);

    always_comb
    begin
        case (state_reg)
            S_DIAG_RD: info_raddr = MAW'(r_reg) + MAW'(r_reg) * MAW'(n_reg);
            S_IRS:     info_raddr = MAW'(r_reg) + MAW'(s_reg) * MAW'(n_reg);
            S_IRT:     info_raddr = MAW'(r_reg) + MAW'(t_reg) * MAW'(n_reg);
            S_ITR:     info_raddr = MAW'(t_reg) + MAW'(r_reg) * MAW'(n_reg);
            S_IRU:     info_raddr = MAW'(r_reg) + MAW'(u_reg) * MAW'(n_reg);
            S_ITU:     info_raddr = MAW'(t_reg) + MAW'(u_reg) * MAW'(n_reg);
            default:   info_raddr = '0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_K2_SQ:   begin mul_a = k2_reg;  mul_b = k2_reg;  end
            S_K2_CUBE: begin mul_a = p_reg;   mul_b = k2_reg;  end
            S_PROD:    begin mul_a = itr_reg; mul_b = iru_reg; end
            S_M1:      begin mul_a = irs_reg; mul_b = irt_reg; end
            S_M2:      begin mul_a = p_reg;   mul_b = iru_reg; end
            S_M3:      begin mul_a = p_reg;   mul_b = a_reg;   end
            S_M4:      begin mul_a = p_reg;   mul_b = k2c_reg; end
            S_M5:      begin mul_a = irs_reg; mul_b = k2_reg;  end
            S_M6:      begin mul_a = p_reg;   mul_b = nu_reg;  end
            S_M7:      begin mul_a = p_reg;   mul_b = ab_reg;  end
            default:   begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    assign mul_y = qmul(mul_a, mul_b);

    assign den_fin = (64'(k2_reg) <<< 2) + (64'(k2_reg) <<< 1);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_DIAG_CHK:
            begin
                div_start = (info_q != '0);
                div_num   = 64'sh1_0000_0000;
                div_den   = 64'(info_q);
            end
            S_NU_START:
            begin
                div_start = 1'b1;
                div_num   = 64'(p_reg) <<< 16;
                div_den   = 64'(d_reg);
            end
            S_FIN_START:
            begin
                div_start = 1'b1;
                div_num   = {third_reg[47:0], 16'h0000};
                div_den   = den_fin;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign div_num_mag = div_num[63] ? 64'(-div_num) : 64'(div_num);
    assign div_den_mag = div_den[63] ? 64'(-div_den) : 64'(div_den);
    assign div_shift   = {div_rem_reg, div_quo_reg[63]};
    assign div_diff    = div_shift - {1'b0, div_dv_reg};
    assign div_q       = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg <= 1'b0;
            div_neg_reg <= 1'b0;
            div_cnt_reg <= '0;
            div_quo_reg <= '0;
            div_rem_reg <= '0;
            div_dv_reg  <= '0;
        end
        else if (div_start)
        begin
            div_run_reg <= 1'b1;
            div_neg_reg <= div_num[63] ^ div_den[63];
            div_cnt_reg <= '0;
            div_quo_reg <= div_num_mag;
            div_rem_reg <= '0;
            div_dv_reg  <= div_den_mag;
        end
        else if (div_run_reg)
        begin
            if (!div_diff[64])
            begin
                div_rem_reg <= div_diff[63:0];
                div_quo_reg <= {div_quo_reg[62:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_shift[63:0];
                div_quo_reg <= {div_quo_reg[62:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (div_cnt_reg == 6'd63)
            begin
                div_run_reg <= 1'b0;
            end
        end
    end

    assign p_wide     = 64'(p_reg);
    assign p_weighted = (t_reg != u_reg) ? (p_wide <<< 1) : p_wide;
    assign fin_sum    = (first_reg >>> 1) + ((den_fin == '0) ? 64'sd0 : div_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dim_reg    <= DIM_RESET;
            n_reg      <= '0;
            r_reg      <= '0;
            s_reg      <= '0;
            t_reg      <= '0;
            u_reg      <= '0;
            d_reg      <= '0;
            k2_reg     <= '0;
            k2c_reg    <= '0;
            p_reg      <= '0;
            nu_reg     <= '0;
            ab_reg     <= '0;
            irs_reg    <= '0;
            irt_reg    <= '0;
            itr_reg    <= '0;
            iru_reg    <= '0;
            itu_reg    <= '0;
            a_reg      <= '0;
            first_reg  <= '0;
            third_reg  <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_we)
            begin
                dim_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (item.op == OP_COMPUTE))
                    begin
                        n_reg     <= n_eff;
                        r_reg     <= '0;
                        state_reg <= S_DIAG_RD;
                    end
                end
                S_DIAG_RD:
                begin
                    first_reg <= '0;
                    third_reg <= '0;
                    s_reg     <= '0;
                    t_reg     <= '0;
                    u_reg     <= '0;
                    state_reg <= S_DIAG_CHK;
                end
                S_DIAG_CHK:
                begin
                    d_reg <= info_q;
                    if (info_q == '0)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.row_index    <= 3'(r_reg);
                        result_reg.adjustment   <= '0;
                        result_reg.divide_error <= 1'b1;
                        result_reg.last         <= row_last;
                        r_reg                   <= r_reg + CW'(1);
                        state_reg               <= row_last ? S_IDLE : S_DIAG_RD;
                    end
                    else
                    begin
                        state_reg <= S_K2_DIV;
                    end
                end
                S_K2_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        k2_reg    <= sat32(div_q);
                        state_reg <= S_K2_SQ;
                    end
                end
                S_K2_SQ:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_K2_CUBE;
                end
                S_K2_CUBE:
                begin
                    k2c_reg   <= mul_y;
                    state_reg <= S_IRS;
                end
                S_IRS:
                begin
                    state_reg <= S_IRT;
                end
                S_IRT:
                begin
                    irs_reg   <= info_q;
                    state_reg <= S_ITR;
                end
                S_ITR:
                begin
                    irt_reg   <= info_q;
                    state_reg <= S_IRU;
                end
                S_IRU:
                begin
                    itr_reg   <= info_q;
                    state_reg <= S_ITU;
                end
                S_ITU:
                begin
                    iru_reg   <= info_q;
                    a_reg     <= third_q;
                    ab_reg    <= sat32(64'(third_q) + 64'(mixed_q));
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    itu_reg   <= info_q;
                    p_reg     <= mul_y;
                    state_reg <= S_NU_START;
                end
                S_NU_START:
                begin
                    state_reg <= S_NU_DIV;
                end
                S_NU_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        nu_reg    <= sat32(64'(itu_reg) - 64'(sat32(div_q)));
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    third_reg <= third_reg + p_weighted;
                    p_reg     <= mul_y;
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    p_reg     <= mul_y;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    first_reg <= first_reg + p_weighted;
                    state_reg <= S_IRS;
                    if (u_reg != n_last)
                    begin
                        u_reg <= u_reg + CW'(1);
                    end
                    else if (t_reg != n_last)
                    begin
                        t_reg <= t_reg + CW'(1);
                        u_reg <= t_reg + CW'(1);
                    end
                    else if (s_reg != n_last)
                    begin
                        s_reg <= s_reg + CW'(1);
                        t_reg <= '0;
                        u_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_FIN_START;
                    end
                end
                S_FIN_START:
                begin
                    state_reg <= S_FIN_DIV;
                end
                S_FIN_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.row_index    <= 3'(r_reg);
                        result_reg.adjustment   <= sat32(fin_sum);
                        result_reg.divide_error <= 1'b0;
                        result_reg.last         <= row_last;
                        r_reg                   <= r_reg + CW'(1);
                        state_reg               <= row_last ? S_IDLE : S_DIAG_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    `MBAT_ASSERT_SAME(a_strobe_after_compute, clk, rst_n, strobe_reg, $past(busy), "result transfer without compute")
    `MBAT_ASSERT_SAME(a_div_no_restart, clk, rst_n, div_start, !div_run_reg, "divider restarted while running")
    `MBAT_ASSERT_SAME(a_err_zero_adj, clk, rst_n, strobe_reg && result_reg.divide_error, result_reg.adjustment == '0, "zero diagonal with nonzero adjustment")
    `MBAT_ASSERT_SAME(a_last_ends_run, clk, rst_n, strobe_reg && result_reg.last, !busy, "busy during last transfer")

endmodule
